// File: hw/rtl/header_type_length_frame_parser_core_defines.svh
// Assertion macros for the type/length frame parser core.
// Included by the RTL files that carry concurrent assertions.
// Synthesis builds define SYNTH so the macros expand to nothing.
`ifndef HEADER_TYPE_LENGTH_FRAME_PARSER_CORE_DEFINES_SVH
`define HEADER_TYPE_LENGTH_FRAME_PARSER_CORE_DEFINES_SVH

`ifndef SYNTH

// Same-cycle implication, disabled while reset is asserted
`define HTLFP_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("htlfp assertion failed");

// Next-cycle implication, disabled while reset is asserted
`define HTLFP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("htlfp assertion failed");

`else

`define HTLFP_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define HTLFP_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// File: hw/rtl/htlfp_pkg.sv
// Package for the type/length frame parser core: parse phases,
// register indexes, reset values and the structs shared between modules.
// No dependencies.
`timescale 1ns / 1ps

package htlfp_pkg;

	// Register indexes (word address bit 2 of the APB port)
	localparam logic CFG_SYNC_FIRST  = 1'b0;
	localparam logic CFG_SYNC_SECOND = 1'b1;

	localparam int unsigned CFG_ADDR_W = 3;
	localparam int unsigned CFG_DATA_W = 32;

	// Register reset values
	localparam logic [7:0] SYNC_FIRST_RST  = 8'h5A;
	localparam logic [7:0] SYNC_SECOND_RST = 8'hA5;

	typedef enum logic [2:0] {
		PH_SYNC1  = 3'd0,
		PH_SYNC2  = 3'd1,
		PH_TYPE   = 3'd2,
		PH_LENGTH = 3'd3,
		PH_DATA   = 3'd4
	} phase_t;

	typedef struct packed {
		logic [7:0] sync_first;
		logic [7:0] sync_second;
	} cfg_t;

	typedef struct packed {
		logic       valid;
		logic [7:0] frame_type;
		logic [7:0] frame_length;
		logic [7:0] payload_byte;
		logic [7:0] byte_index;
		logic       last;
		logic       empty_frame;
	} res_t;

endpackage

// File: hw/rtl/htlfp_if.sv
// Valid/ready channel interfaces for the frame parser core:
// the received byte stream and the parsed result stream.
// No dependencies.
`timescale 1ns / 1ps

interface htlfp_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;

	modport source (output valid, output in_byte, input ready);
	modport sink (input valid, input in_byte, output ready);
endinterface

interface htlfp_result_if;
	logic       valid;
	logic       ready;
	logic [7:0] frame_type;
	logic [7:0] frame_length;
	logic [7:0] payload_byte;
	logic [7:0] byte_index;
	logic       last;
	logic       empty_frame;

	modport source (output valid, output frame_type, output frame_length,
		output payload_byte, output byte_index, output last, output empty_frame,
		input ready);
	modport sink (input valid, input frame_type, input frame_length,
		input payload_byte, input byte_index, input last, input empty_frame,
		output ready);
endinterface

// File: hw/rtl/htlfp_cfg.sv
// APB-style register file of the frame parser: the two sync bytes.
// Depends on htlfp_pkg.
`timescale 1ns / 1ps

module htlfp_cfg
	import htlfp_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [CFG_ADDR_W-1:0] paddr,
	input  logic [CFG_DATA_W-1:0] pwdata,
	output logic [CFG_DATA_W-1:0] prdata,
	output logic                  pready,
	output cfg_t                  cfg
);

	logic [7:0] sync_first_q;
	logic [7:0] sync_second_q;
	logic       wr_en;
	logic       reg_sel;

	assign pready  = 1'b1;
	assign wr_en   = psel & penable & pwrite;
	assign reg_sel = paddr[2];

	// Write the addressed sync byte; only the low byte of the data counts
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sync_first_q  <= SYNC_FIRST_RST;
			sync_second_q <= SYNC_SECOND_RST;
		end else if (wr_en) begin
			unique case (reg_sel)
				CFG_SYNC_FIRST:  sync_first_q  <= pwdata[7:0];
				CFG_SYNC_SECOND: sync_second_q <= pwdata[7:0];
				default:         sync_first_q  <= sync_first_q;
			endcase
		end
	end

	// Read back the addressed register
	always_comb begin
		prdata = '0;
		unique case (reg_sel)
			CFG_SYNC_FIRST:  prdata[7:0] = sync_first_q;
			CFG_SYNC_SECOND: prdata[7:0] = sync_second_q;
			default:         prdata      = '0;
		endcase
	end

	assign cfg.sync_first  = sync_first_q;
	assign cfg.sync_second = sync_second_q;

endmodule

// File: hw/rtl/htlfp_fsm.sv
// Frame parse state machine: phase, held type/length and remaining count,
// and the result that the current byte produces.
// Depends on htlfp_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "header_type_length_frame_parser_core_defines.svh"

module htlfp_fsm
	import htlfp_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  cfg_t       cfg,
	input  logic       step,
	input  logic [7:0] byte_val,
	output res_t       res
);

	phase_t     phase_q, phase_d;
	logic [7:0] type_q, type_d;
	logic [7:0] length_q, length_d;
	logic [7:0] left_q, left_d;
	logic       fin;

	// State registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_SYNC1;
			type_q   <= '0;
			length_q <= '0;
			left_q   <= '0;
		end else if (step) begin
			phase_q  <= phase_d;
			type_q   <= type_d;
			length_q <= length_d;
			left_q   <= left_d;
		end
	end

	assign fin = (left_q <= 8'd1);

	// Next state and result for the current byte
	always_comb begin
		phase_d          = phase_q;
		type_d           = type_q;
		length_d         = length_q;
		left_d           = left_q;
		res.valid        = 1'b0;
		res.frame_type   = type_q;
		res.frame_length = length_q;
		res.payload_byte = byte_val;
		res.byte_index   = 8'(length_q - left_q);
		res.last         = fin;
		res.empty_frame  = 1'b0;
		unique case (phase_q)
			PH_SYNC1: begin
				if (byte_val == cfg.sync_first) phase_d = PH_SYNC2;
			end
			PH_SYNC2: begin
				phase_d = (byte_val == cfg.sync_second) ? PH_TYPE : PH_SYNC1;
			end
			PH_TYPE: begin
				type_d  = byte_val;
				phase_d = PH_LENGTH;
			end
			PH_LENGTH: begin
				length_d = byte_val;
				left_d   = byte_val;
				if (byte_val == 8'd0) begin
					// Empty frame: one result marked empty and last
					res.valid        = step;
					res.frame_length = 8'd0;
					res.payload_byte = 8'd0;
					res.byte_index   = 8'd0;
					res.last         = 1'b1;
					res.empty_frame  = 1'b1;
					phase_d          = PH_SYNC1;
				end else begin
					phase_d = PH_DATA;
				end
			end
			PH_DATA: begin
				res.valid = step;
				if (fin) begin
					left_d  = 8'd0;
					phase_d = PH_SYNC1;
				end else begin
					left_d = 8'(left_q - 8'd1);
				end
			end
			default: begin
				phase_d = PH_SYNC1;
			end
		endcase
	end

	`HTLFP_ASSERT_SAME(a_data_has_count, clk, arst_n, phase_q == PH_DATA, left_q != 8'd0)
	`HTLFP_ASSERT_NEXT(a_last_byte_rehunts, clk, arst_n, step && phase_q == PH_DATA && left_q == 8'd1, phase_q == PH_SYNC1)
	`HTLFP_ASSERT_SAME(a_empty_is_last, clk, arst_n, res.valid && res.empty_frame, res.last && res.payload_byte == 8'd0)

endmodule

// File: hw/rtl/header_type_length_frame_parser_core.sv
// Type/length frame parser core, one byte per cycle.
// An accepted byte passes through the input register and is then parsed into the
// result register. Throughput: one byte per cycle; a stalled result holds the
// input register, which then holds ready low.
// Reset (arst_n low, asynchronous): parser hunts the first sync byte, sync
// bytes return to 0x5A / 0xA5, both channel registers empty.
`timescale 1ns / 1ps
`include "header_type_length_frame_parser_core_defines.svh"

module header_type_length_frame_parser_core
	import htlfp_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	htlfp_byte_if.sink            stream,
	htlfp_result_if.source        result,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [CFG_ADDR_W-1:0] paddr,
	input  logic [CFG_DATA_W-1:0] pwdata,
	output logic [CFG_DATA_W-1:0] prdata,
	output logic                  pready
);

	cfg_t       cfg;
	res_t       res;
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       out_free;
	logic       step;
	logic       out_valid_q;
	res_t       out_q;

	htlfp_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// Parse one byte when the result register can take whatever it yields
	assign out_free     = !out_valid_q || result.ready;
	assign step         = valid_s1 && out_free;
	assign stream.ready = !valid_s1 || out_free;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (stream.ready) begin
			valid_s1 <= stream.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (stream.ready && stream.valid) begin
			byte_s1 <= stream.in_byte;
		end
	end

	htlfp_fsm u_fsm (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.step     (step),
		.byte_val (byte_s1),
		.res      (res)
	);

	// Result register: load a new result, drop a delivered one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= res.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && res.valid) begin
			out_q <= res;
		end
	end

	assign result.valid        = out_valid_q;
	assign result.frame_type   = out_q.frame_type;
	assign result.frame_length = out_q.frame_length;
	assign result.payload_byte = out_q.payload_byte;
	assign result.byte_index   = out_q.byte_index;
	assign result.last         = out_q.last;
	assign result.empty_frame  = out_q.empty_frame;

	`HTLFP_ASSERT_SAME(a_result_needs_step, clk, arst_n, res.valid, step && out_free)
	`HTLFP_ASSERT_NEXT(a_stall_holds_input, clk, arst_n, valid_s1 && !out_free, valid_s1 && $stable(byte_s1))
	`HTLFP_ASSERT_NEXT(a_result_loaded, clk, arst_n, res.valid, out_valid_q)

endmodule

// File: dv/htlfp_checker.sv
// Scoreboard for the type/length frame parser: tracks sync, header and payload
// from the byte stream and the APB writes, and compares every result transaction.
// Depends on htlfp_pkg and the channel interfaces in htlfp_if.sv.
`timescale 1ns / 1ps

module htlfp_checker
	import htlfp_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	htlfp_byte_if                 stream,
	htlfp_result_if               result,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic                  pready,
	input  logic [CFG_ADDR_W-1:0] paddr,
	input  logic [CFG_DATA_W-1:0] pwdata,
	output int unsigned           mismatches,
	output int unsigned           beats_due
);

	typedef struct packed {
		logic [7:0] frame_type;
		logic [7:0] frame_length;
		logic [7:0] payload_byte;
		logic [7:0] byte_index;
		logic       last;
		logic       empty_frame;
	} payload_beat_t;

	payload_beat_t beat_q[$];
	int unsigned   fail_cnt = 0;

	// Parser mirror: sync bytes, phase and held header
	logic [7:0] sync_lead   = SYNC_FIRST_RST;
	logic [7:0] sync_follow = SYNC_SECOND_RST;
	phase_t     phase       = PH_SYNC1;
	logic [7:0] hdr_type    = '0;
	logic [7:0] hdr_len     = '0;
	logic [7:0] remaining   = '0;

	// Advance the parser mirror by one byte; queue the payload beat it yields
	task automatic parse_byte(input logic [7:0] b);
		payload_beat_t beat;
		logic          fin;
		case (phase)
			PH_SYNC1: begin
				if (b == sync_lead)
					phase = PH_SYNC2;
			end
			PH_SYNC2: begin
				phase = (b == sync_follow) ? PH_TYPE : PH_SYNC1;
			end
			PH_TYPE: begin
				hdr_type = b;
				phase = PH_LENGTH;
			end
			PH_LENGTH: begin
				hdr_len = b;
				remaining = b;
				if (b == 8'd0) begin
					beat = '{hdr_type, 8'd0, 8'd0, 8'd0, 1'b1, 1'b1};
					beat_q.push_back(beat);
					phase = PH_SYNC1;
				end else begin
					phase = PH_DATA;
				end
			end
			PH_DATA: begin
				fin = (remaining <= 8'd1);
				beat = '{hdr_type, hdr_len, b, 8'(hdr_len - remaining), fin, 1'b0};
				beat_q.push_back(beat);
				if (fin) begin
					remaining = 8'd0;
					phase = PH_SYNC1;
				end else begin
					remaining = remaining - 8'd1;
				end
			end
			default: begin
				phase = PH_SYNC1;
			end
		endcase
	endtask

	task automatic cmp_field(input string name, input logic [7:0] exp_v, input logic [7:0] act_v);
		if (exp_v !== act_v) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
			fail_cnt++;
		end
	endtask

	// Compare one result transaction with the oldest queued beat
	task automatic check_beat();
		payload_beat_t beat;
		if (beat_q.size() == 0) begin
			$error("result transaction with nothing expected: type 0x%0h index 0x%0h",
				result.frame_type, result.byte_index);
			fail_cnt++;
		end else begin
			beat = beat_q.pop_front();
			cmp_field("frame_type", beat.frame_type, result.frame_type);
			cmp_field("frame_length", beat.frame_length, result.frame_length);
			cmp_field("payload_byte", beat.payload_byte, result.payload_byte);
			cmp_field("byte_index", beat.byte_index, result.byte_index);
			cmp_field("last", 8'(beat.last), 8'(result.last));
			cmp_field("empty_frame", 8'(beat.empty_frame), 8'(result.empty_frame));
		end
	endtask

	// Watch config writes and both channels at every edge
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sync_lead = SYNC_FIRST_RST;
			sync_follow = SYNC_SECOND_RST;
			phase = PH_SYNC1;
			hdr_type = '0;
			hdr_len = '0;
			remaining = '0;
			beat_q.delete();
		end else begin
			if (psel && penable && pwrite && pready) begin
				if (paddr[2] == CFG_SYNC_FIRST)
					sync_lead = pwdata[7:0];
				else
					sync_follow = pwdata[7:0];
			end
			if (stream.valid && stream.ready)
				parse_byte(stream.in_byte);
			if (result.valid && result.ready)
				check_beat();
		end
		mismatches <= fail_cnt;
		beats_due <= beat_q.size();
	end

endmodule

// File: dv/tb_top.sv
// Testbench top for the type/length frame parser core: clock, reset, APB
// sync-byte setup, byte stream stimulus, result back-pressure and verdict.
// Depends on htlfp_pkg, htlfp_if.sv, the core RTL and htlfp_checker.
`timescale 1ns / 1ps

module tb_top;
	import htlfp_pkg::*;

	localparam int unsigned DRAIN_CYCLES   = 4;
	localparam int unsigned WATCHDOG_LIMIT = 1000;
	localparam int unsigned PHASE_BYTES    = 80;
	localparam int unsigned HOLD_CYCLES    = 60;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  psel;
	logic                  penable;
	logic                  pwrite;
	logic [CFG_ADDR_W-1:0] paddr;
	logic [CFG_DATA_W-1:0] pwdata;
	logic [CFG_DATA_W-1:0] prdata;
	logic                  pready;
	int unsigned           mismatches;
	int unsigned           beats_due;

	logic [7:0]  cur_first = SYNC_FIRST_RST;
	logic [7:0]  cur_second = SYNC_SECOND_RST;
	int unsigned burst_left = 0;
	int unsigned frame_bytes = 0;
	int unsigned idle_cycles = 0;
	logic        long_frame = 1'b0;

	htlfp_byte_if   stream_if ();
	htlfp_result_if result_if ();

	header_type_length_frame_parser_core dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.stream  (stream_if),
		.result  (result_if),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	htlfp_checker chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.stream     (stream_if),
		.result     (result_if),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.pready     (pready),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.mismatches (mismatches),
		.beats_due  (beats_due)
	);

	always #5 clk = ~clk;

	// Offer one byte, in bursts with random gaps; return at its handshake
	task automatic push_byte(input logic [7:0] b);
		int unsigned gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			burst_left = $urandom_range(1, 24);
			if (gap != 0) begin
				stream_if.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		stream_if.valid <= 1'b1;
		stream_if.in_byte <= b;
		@(posedge clk);
		while (!stream_if.ready) @(posedge clk);
	endtask

	// Drop valid, wait for every queued beat, then let the pipeline drain
	task automatic go_idle();
		stream_if.valid <= 1'b0;
		burst_left = 0;
		@(posedge clk);
		while (beats_due != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// APB write: setup cycle, then access cycle; junk in the upper bits
	task automatic cfg_write(input logic idx, input logic [7:0] val);
		logic [31:0] junk;
		junk = $urandom();
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= {junk[31:8], val};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic set_sync(input logic [7:0] first_b, input logic [7:0] second_b);
		cfg_write(CFG_SYNC_FIRST, first_b);
		cfg_write(CFG_SYNC_SECOND, second_b);
		cur_first = first_b;
		cur_second = second_b;
	endtask

	task automatic send_frame(input int unsigned len);
		logic [7:0] ftype;
		ftype = 8'($urandom_range(0, 255));
		push_byte(cur_first);
		push_byte(cur_second);
		push_byte(ftype);
		push_byte(len[7:0]);
		for (int i = 0; i < len; i++)
			push_byte(8'($urandom_range(0, 255)));
		frame_bytes += 4 + len;
	endtask

	// Mostly short frames, some empty, a few long ones
	function automatic int unsigned pick_length();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 10)
			return 0;
		if (r < 80)
			return $urandom_range(1, 8);
		if (r < 98)
			return $urandom_range(9, 40);
		return $urandom_range(200, 254);
	endfunction

	// Well-formed frames with random content, plus noise and broken headers
	task automatic run_random(input int unsigned budget);
		int unsigned start;
		int unsigned pick;
		int unsigned n;
		logic [7:0]  b;
		start = frame_bytes;
		while (frame_bytes - start < budget) begin
			pick = $urandom_range(0, 99);
			if (pick < 75) begin
				send_frame(pick_length());
			end else if (pick < 88) begin
				// noise that never hits the first sync byte
				n = $urandom_range(1, 4);
				repeat (n) begin
					b = 8'($urandom_range(0, 255));
					if (b == cur_first)
						b = ~b;
					push_byte(b);
				end
			end else begin
				// first sync byte followed by a wrong second one
				b = cur_second ^ 8'($urandom_range(1, 255));
				if ($urandom_range(0, 2) == 0 && cur_first != cur_second)
					b = cur_first;
				push_byte(cur_first);
				push_byte(b);
				frame_bytes += 2;
			end
		end
	endtask

	// Result back-pressure: random modes, plus one long hold-off during the long frame
	initial begin
		int unsigned hold_left;
		int unsigned mode;
		int unsigned mode_left;
		bit          hold_done;
		hold_left = 0;
		mode = 0;
		mode_left = 0;
		hold_done = 1'b0;
		result_if.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_left != 0) begin
				hold_left--;
				result_if.ready <= 1'b0;
			end else if (long_frame && !hold_done) begin
				hold_done = 1'b1;
				hold_left = HOLD_CYCLES - 1;
				result_if.ready <= 1'b0;
			end else begin
				if (mode_left == 0) begin
					mode = $urandom_range(0, 2);
					mode_left = $urandom_range(8, 48);
				end
				mode_left--;
				case (mode)
					0: result_if.ready <= 1'b1;
					1: result_if.ready <= ($urandom_range(0, 3) != 0);
					default: result_if.ready <= 1'(($urandom_range(0, 1)));
				endcase
			end
		end
	end

	// Watchdog: end the run after too long without any transaction
	always @(posedge clk) begin
		if ((stream_if.valid && stream_if.ready) || (result_if.valid && result_if.ready)
			|| (psel && penable))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("tb_top NOT OK");
			$finish;
		end
	end

	// Stimulus and verdict
	initial begin
		logic [7:0] seed_bytes [20];
		seed_bytes = '{8'hFF, 8'h00,
			SYNC_FIRST_RST, SYNC_FIRST_RST, SYNC_SECOND_RST,
			SYNC_FIRST_RST, SYNC_SECOND_RST, 8'h00, 8'h00,
			SYNC_FIRST_RST, SYNC_SECOND_RST, 8'hFF, 8'h01, 8'hFF,
			SYNC_FIRST_RST, SYNC_SECOND_RST, 8'h80, 8'h02, 8'h00, 8'h7F};
		stream_if.valid = 1'b0;
		stream_if.in_byte = 8'h00;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// noise, wrong second sync, empty frame, one-byte and two-byte frames
		foreach (seed_bytes[i])
			push_byte(seed_bytes[i]);
		run_random(PHASE_BYTES);
		go_idle();

		set_sync(8'h00, 8'hFF);
		run_random(PHASE_BYTES);
		go_idle();

		// longest frame: index runs up to 254; the receiver holds off meanwhile
		set_sync(8'hFF, 8'h00);
		long_frame = 1'b1;
		send_frame(255);
		long_frame = 1'b0;
		run_random(PHASE_BYTES);
		go_idle();

		set_sync(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
		run_random(PHASE_BYTES);
		go_idle();

		// same value for both sync bytes
		cur_first = 8'($urandom_range(0, 255));
		set_sync(cur_first, cur_first);
		run_random(PHASE_BYTES);
		go_idle();

		if (mismatches == 0)
			$display("tb_top OK");
		else
			$display("tb_top NOT OK");
		$finish;
	end

endmodule
